[hw/rtl/tks_pkg.sv]
// Package for the top-k smallest selector: fixed constants, controller state
// encoding and the command/status structs between controller and datapath.
// No dependencies.
package tks_pkg;

   // Width and reset value of the keep count register
   localparam int KEEP_CNT_W = 5;
   localparam logic [KEEP_CNT_W-1:0] KEEP_CNT_RESET = 5'd10;

   // Controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_REPORT = 2'b10
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic insert;   // insert the accepted sample
      logic restart;  // accepted sample closes the set: rewind the report index
      logic load;     // load the next kept entry into the output register
      logic finish;   // final entry loaded: empty the list
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free; // output register empty or being taken this cycle
      logic last_idx; // report index points at the final kept entry
   } dp_status_type;

endpackage

[hw/rtl/tks_chan_if.sv]
// Valid/ready channel interfaces for the top-k smallest selector.
// Depends on nothing; widths come from the instantiating level.
interface tks_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample_value;
   logic                          last_of_set;

   modport source (output valid, input ready, output sample_value, output last_of_set);
   modport sink   (input valid, output ready, input sample_value, input last_of_set);
endinterface

interface tks_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int RANK_WIDTH  = 4
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] kept_value;
   logic        [RANK_WIDTH-1:0]  rank;
   logic                          last_in_run;

   modport source (output valid, input ready, output kept_value, output rank,
                   output last_in_run);
   modport sink   (input valid, output ready, input kept_value, input rank,
                   input last_in_run);
endinterface

[hw/rtl/tks_ctl.sv]
// Controller of the top-k smallest selector: accepts samples and sequences
// the report run. Depends on tks_pkg.
module tks_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   output tks_pkg::dp_cmd_type    cmd,
   input  tks_pkg::dp_status_type status
);
   import tks_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   // Take samples only outside a report run
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Drive the datapath
   always_comb begin
      cmd.insert  = accept;
      cmd.restart = accept && req_last;
      cmd.load    = (state_ff == ST_REPORT) && status.out_free;
      cmd.finish  = (state_ff == ST_REPORT) && status.out_free && status.last_idx;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.out_free && status.last_idx) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[hw/rtl/tks_dp.sv]
// Datapath of the top-k smallest selector: keep count register, sorted slot
// list with per-slot compare-and-shift, list size, report index and output
// register. Depends on tks_pkg.
module tks_dp #(
   parameter int MAX_KEEP    = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int RANK_WIDTH  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tks_pkg::KEEP_CNT_W-1:0]    csr_write_data,
   input  logic signed [VALUE_WIDTH-1:0]     sample_value,
   input  tks_pkg::dp_cmd_type               cmd,
   output tks_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]     rsp_kept_value,
   output logic [RANK_WIDTH-1:0]             rsp_rank,
   output logic                              rsp_last_in_run
);
   import tks_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEEP + 1);

   logic [KEEP_CNT_W-1:0]         keep_count_ff;
   logic [CNT_W-1:0]              keep_eff;
   logic [CNT_W-1:0]              size_ff;
   logic [CNT_W-1:0]              size_in;
   logic [CNT_W-1:0]              fill;
   logic signed [VALUE_WIDTH-1:0] slot_ff [MAX_KEEP];
   logic [MAX_KEEP-1:0]           not_above;
   logic [MAX_KEEP-1:0]           slot_wr;
   logic [RANK_WIDTH-1:0]         idx_ff;
   logic                          rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [RANK_WIDTH-1:0]         rsp_rank_ff;
   logic                          rsp_last_ff;

   // Keep count register
   always_ff @(posedge clock) begin
      if (reset)             keep_count_ff <= KEEP_CNT_RESET;
      else if (csr_write_en) keep_count_ff <= csr_write_data;
   end

   // Clamp the keep count to 1..MAX_KEEP
   always_comb begin
      if (keep_count_ff == '0)                keep_eff = CNT_W'(1);
      else if (int'(keep_count_ff) > MAX_KEEP) keep_eff = CNT_W'(MAX_KEEP);
      else                                     keep_eff = CNT_W'(keep_count_ff);
   end

   // Entries still valid under the current keep count
   assign fill = (size_ff < keep_eff) ? size_ff : keep_eff;

   // Per-slot compare and shift
   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_slot
      logic signed [VALUE_WIDTH-1:0] slot_in;

      // Slot holds a valid entry not greater than the sample
      assign not_above[i] = (CNT_W'(i) < fill) && (slot_ff[i] <= sample_value);
      assign slot_wr[i]   = cmd.insert && !not_above[i] && (CNT_W'(i) < keep_eff);

      if (i == 0) begin : g_head
         assign slot_in = sample_value;
      end else begin : g_body
         logic at_pos;
         assign at_pos  = not_above[i-1];
         assign slot_in = at_pos ? sample_value : slot_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (slot_wr[i]) slot_ff[i] <= slot_in;
      end
   end

   // List size: grow on insertion into a list not yet full, clear after report
   always_comb begin
      size_in = fill;
      if (cmd.finish)
         size_in = '0;
      else if (cmd.insert && (|slot_wr) && (fill < keep_eff))
         size_in = fill + CNT_W'(1);
      else if (!cmd.insert)
         size_in = size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) size_ff <= '0;
      else       size_ff <= size_in;
   end

   // Report index
   always_ff @(posedge clock) begin
      if (cmd.restart)   idx_ff <= '0;
      else if (cmd.load) idx_ff <= idx_ff + RANK_WIDTH'(1);
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.last_idx = (CNT_W'(idx_ff) + CNT_W'(1)) == size_ff;

   // Output register: hold until transfer, load next entry when free
   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.load)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_value_ff <= slot_ff[idx_ff[$clog2(MAX_KEEP > 1 ? MAX_KEEP : 2)-1:0]];
         rsp_rank_ff  <= idx_ff;
         rsp_last_ff  <= status.last_idx;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_value  = rsp_value_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_last_in_run = rsp_last_ff;

endmodule

[hw/rtl/top_k_smallest_selector_core.sv]
// Top level of the top-k smallest selector: controller, datapath and channel
// wiring. Depends on tks_pkg, tks_chan_if, tks_ctl and tks_dp.
//
// Usage:
//   req_chan carries sample_value (signed) and last_of_set. A sample is taken
//   at a clock edge with valid and ready high; outside a report run ready is
//   high, so one sample is inserted per cycle into a sorted list of the
//   keep_count smallest values (ties go after equal entries).
//   csr_write_en/csr_write_data set keep_count (0 acts as 1, values above
//   MAX_KEEP act as MAX_KEEP); write it only while the block is idle.
//   A sample with last_of_set starts a report run: the controller enters its
//   report state and the output register loads each result once it is free,
//   one result per cycle on rsp_chan while the receiver takes every result
//   (kept_value ascending, rank from 0, last_in_run on the final one).
//   Req ready stays low for the whole run; the throughput of a run is set by
//   the single output register. When the receiver stalls, the output
//   register holds its result and the run pauses. The last result may still
//   wait while new samples are taken. Reset (synchronous) empties the list,
//   drops any pending result and sets keep_count to 10.
module top_k_smallest_selector_core #(
   parameter int MAX_KEEP    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [tks_pkg::KEEP_CNT_W-1:0] csr_write_data,
   tks_req_if.sink                        req_chan,
   tks_rsp_if.source                      rsp_chan
);
   import tks_pkg::*;

   localparam int RANK_WIDTH = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   dp_cmd_type    cmd;
   dp_status_type status;

   tks_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_of_set),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tks_dp #(
      .MAX_KEEP    (MAX_KEEP),
      .VALUE_WIDTH (VALUE_WIDTH),
      .RANK_WIDTH  (RANK_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .sample_value    (req_chan.sample_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kept_value  (rsp_chan.kept_value),
      .rsp_rank        (rsp_chan.rank),
      .rsp_last_in_run (rsp_chan.last_in_run)
   );

endmodule
